FILE: rtl/cca_pkg.sv
// ----------------------------------------------------------------------------
// cca_pkg
// Shared types, microcode encodings and cost tables for the cluster cache
// access timing block.
// ----------------------------------------------------------------------------
package cca_pkg;

    // widths of the fixed item fields
    localparam int CMD_W   = 2;
    localparam int HIDX_W  = 4;
    localparam int WORD_W  = 32;
    localparam int TICKS_W = 48;
    localparam int OVH_W   = 20;
    localparam int FW_W    = 2;
    localparam int CFG_IDX_W = 8;
    // widest single increment of the tick accumulator (superblock write)
    localparam int ADD_W   = 22;

    // commands
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRMWARE_CLASS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD       = 8'd1;

    // firmware classes
    localparam logic [FW_W-1:0] FW_OLD   = 2'd0;
    localparam logic [FW_W-1:0] FW_MID   = 2'd1;
    localparam logic [FW_W-1:0] FW_OTHER = 2'd2;

    // memcpy cost scaling: 636 / 1000, division by reciprocal floor(2^32 / 1000)
    localparam int MEMCPY_MUL   = 636;
    localparam int MEMCPY_DIV   = 1000;
    localparam int RECIP_SHIFT  = 32;
    localparam int RECIP_W      = 23;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 23'd4294967;
    localparam int MEMCPY_BIAS  = 150;
    localparam int MEMCPY_OLD_BIAS = 3;
    localparam int FREE_CHECK_TICKS = 1000;

    // microcode operation codes
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE        = 4'd0;
    localparam logic [OP_W-1:0] OP_LATCH       = 4'd1;
    localparam logic [OP_W-1:0] OP_CLIP        = 4'd2;
    localparam logic [OP_W-1:0] OP_LEN         = 4'd3;
    localparam logic [OP_W-1:0] OP_FLUSH_MISS  = 4'd4;
    localparam logic [OP_W-1:0] OP_FILL        = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL         = 4'd6;
    localparam logic [OP_W-1:0] OP_QUO         = 4'd7;
    localparam logic [OP_W-1:0] OP_FIX         = 4'd8;
    localparam logic [OP_W-1:0] OP_COPY        = 4'd9;
    localparam logic [OP_W-1:0] OP_END_PIECE   = 4'd10;
    localparam logic [OP_W-1:0] OP_DIRECT      = 4'd11;
    localparam logic [OP_W-1:0] OP_CLOSE_FLUSH = 4'd12;
    localparam logic [OP_W-1:0] OP_CLOSE_SB    = 4'd13;
    localparam logic [OP_W-1:0] OP_EMIT        = 4'd14;

    // microcode sequencing kinds
    localparam int NX_W = 3;
    localparam logic [NX_W-1:0] NX_SEQ       = 3'd0;
    localparam logic [NX_W-1:0] NX_JUMP      = 3'd1;
    localparam logic [NX_W-1:0] NX_WAIT_IN   = 3'd2;
    localparam logic [NX_W-1:0] NX_IF_CLOSE  = 3'd3;
    localparam logic [NX_W-1:0] NX_IF_NOP    = 3'd4;
    localparam logic [NX_W-1:0] NX_IF_DONE   = 3'd5;
    localparam logic [NX_W-1:0] NX_IF_DIRECT = 3'd6;
    localparam logic [NX_W-1:0] NX_WAIT_OUT  = 3'd7;

    // program steps
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] ST_IDLE        = 5'd0;
    localparam logic [STEP_W-1:0] ST_CLIP        = 5'd1;
    localparam logic [STEP_W-1:0] ST_DISPATCH    = 5'd2;
    localparam logic [STEP_W-1:0] ST_LOOP        = 5'd3;
    localparam logic [STEP_W-1:0] ST_CHOOSE      = 5'd4;
    localparam logic [STEP_W-1:0] ST_FLUSH       = 5'd5;
    localparam logic [STEP_W-1:0] ST_FILL        = 5'd6;
    localparam logic [STEP_W-1:0] ST_MUL         = 5'd7;
    localparam logic [STEP_W-1:0] ST_QUO         = 5'd8;
    localparam logic [STEP_W-1:0] ST_FIX         = 5'd9;
    localparam logic [STEP_W-1:0] ST_COPY        = 5'd10;
    localparam logic [STEP_W-1:0] ST_END         = 5'd11;
    localparam logic [STEP_W-1:0] ST_DIRECT      = 5'd12;
    localparam logic [STEP_W-1:0] ST_CLOSE_FLUSH = 5'd13;
    localparam logic [STEP_W-1:0] ST_CLOSE_SB    = 5'd14;
    localparam logic [STEP_W-1:0] ST_EMIT        = 5'd15;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [NX_W-1:0]   nxt;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    // microprogram rom
    function automatic ctrl_word_t rom_word(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        unique case (step)
            ST_IDLE:        w = '{OP_LATCH,       NX_WAIT_IN,   ST_IDLE};
            ST_CLIP:        w = '{OP_CLIP,        NX_IF_CLOSE,  ST_CLOSE_FLUSH};
            ST_DISPATCH:    w = '{OP_NONE,        NX_IF_NOP,    ST_EMIT};
            ST_LOOP:        w = '{OP_LEN,         NX_IF_DONE,   ST_EMIT};
            ST_CHOOSE:      w = '{OP_NONE,        NX_IF_DIRECT, ST_DIRECT};
            ST_FLUSH:       w = '{OP_FLUSH_MISS,  NX_SEQ,       ST_IDLE};
            ST_FILL:        w = '{OP_FILL,        NX_SEQ,       ST_IDLE};
            ST_MUL:         w = '{OP_MUL,         NX_SEQ,       ST_IDLE};
            ST_QUO:         w = '{OP_QUO,         NX_SEQ,       ST_IDLE};
            ST_FIX:         w = '{OP_FIX,         NX_SEQ,       ST_IDLE};
            ST_COPY:        w = '{OP_COPY,        NX_SEQ,       ST_IDLE};
            ST_END:         w = '{OP_END_PIECE,   NX_JUMP,      ST_LOOP};
            ST_DIRECT:      w = '{OP_DIRECT,      NX_JUMP,      ST_LOOP};
            ST_CLOSE_FLUSH: w = '{OP_CLOSE_FLUSH, NX_SEQ,       ST_IDLE};
            ST_CLOSE_SB:    w = '{OP_CLOSE_SB,    NX_SEQ,       ST_IDLE};
            ST_EMIT:        w = '{OP_EMIT,        NX_WAIT_OUT,  ST_IDLE};
            default:        w = '{OP_NONE,        NX_JUMP,      ST_IDLE};
        endcase
        return w;
    endfunction

    // per-class tick costs; the unused class code behaves as "other"
    function automatic logic [ADD_W-1:0] cost_cluster_read(input logic [FW_W-1:0] fw);
        logic [ADD_W-1:0] c;
        priority if (fw == FW_MID) c = ADD_W'(125000);
        else if (fw == FW_OLD)     c = ADD_W'(165000);
        else                       c = ADD_W'(115000);
        return c;
    endfunction

    function automatic logic [ADD_W-1:0] cost_cluster_write(input logic [FW_W-1:0] fw);
        return (fw == FW_OLD) ? ADD_W'(370000) : ADD_W'(300000);
    endfunction

    function automatic logic [ADD_W-1:0] cost_superblock(input logic [FW_W-1:0] fw);
        logic [ADD_W-1:0] c;
        priority if (fw == FW_MID) c = ADD_W'(3350000);
        else if (fw == FW_OLD)     c = ADD_W'(4100000);
        else                       c = ADD_W'(3170000);
        return c;
    endfunction

endpackage

FILE: rtl/cluster_cache_access_timing.sv
// Steps: a cached read or write piece passes the flush, fill, multiply, quotient,
// fix, copy and end-piece steps, an aligned uncached full cluster the direct step;
// a close passes the close-flush and close-superblock steps before its result.
// Throughput: one item at a time; the microprogram walks one cluster piece per
// pass through the shared accumulator adder and the memcpy multiplier.
// Reset: cache tag, dirty and superblock flags clear, firmware class 2, no overhead.
// ----------------------------------------------------------------------------
// cluster_cache_access_timing
// Microcoded tick estimator for a flash file store with a single-cluster
// write-back cache; one result item per request item, whatever its command.
// ----------------------------------------------------------------------------
module cluster_cache_access_timing #(
    parameter int HANDLE_SLOTS  = 16,
    parameter int CLUSTER_BYTES = 16384
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cca_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cca_pkg::OVH_W-1:0]            cfg_data,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [cca_pkg::CMD_W-1:0]            command,
    input  logic [cca_pkg::HIDX_W-1:0]           handle_index,
    input  logic [cca_pkg::WORD_W-1:0]           current_offset,
    input  logic [cca_pkg::WORD_W-1:0]           request_size,
    input  logic [cca_pkg::WORD_W-1:0]           file_length,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [cca_pkg::TICKS_W-1:0]          total_ticks
);
    import cca_pkg::*;

    // cluster size must be a power of two; the block itself does not check it
    localparam int HW  = (HANDLE_SLOTS > 1) ? $clog2(HANDLE_SLOTS) : 1;
    localparam int CL  = $clog2(CLUSTER_BYTES);
    localparam int LW  = CL + 1;
    localparam int PW  = LW + 10;
    localparam int QW  = PW - 9;
    localparam int MW  = PW + RECIP_W;
    localparam int TAG_W = 16;

    // handle slot reduction by repeated subtract on the narrow index
    function automatic logic [HW-1:0] handle_mod(input logic [HIDX_W-1:0] idx);
        logic [6:0] v;
        v = 7'(idx);
        for (int i = 0; i < 8; i++)
        begin
            if (v >= 7'(HANDLE_SLOTS))
            begin
                v = v - 7'(HANDLE_SLOTS);
            end
        end
        return v[HW-1:0];
    endfunction

    // configuration registers
    logic [FW_W-1:0]    fw_reg;
    logic [OVH_W-1:0]   overhead_reg;

    // sequencer and item registers
    logic [STEP_W-1:0]  upc_reg, upc_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [HW-1:0]      h_reg, h_next;
    logic [WORD_W-1:0]  off_reg, off_next;
    logic [WORD_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0]  fsize_reg, fsize_next;
    logic [TICKS_W-1:0] acc_reg, acc_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [PW-1:0]      prod_reg, prod_next;
    logic [QW-1:0]      quo_reg, quo_next;

    // cache and superblock state
    logic               cvalid_reg, cvalid_next;
    logic [HW-1:0]      chandle_reg, chandle_next;
    logic [TAG_W-1:0]   ccluster_reg, ccluster_next;
    logic               cdirty_reg, cdirty_next;
    logic [HANDLE_SLOTS-1:0] sb_reg, sb_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [TICKS_W-1:0] ticks_reg, ticks_next;

    ctrl_word_t         cw;
    logic               hit;
    logic               is_wr;
    logic               direct;
    logic               out_free;
    logic               flush_req;
    logic [ADD_W-1:0]   add_val;
    logic [LW-1:0]      room;
    logic [WORD_W-1:0]  off_adv;
    logic [MW-1:0]      recip_prod;
    logic [PW-1:0]      rem;
    logic [ADD_W-1:0]   memcpy_cost;

    assign cfg_ready   = 1'b1;
    assign in_ready    = (upc_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign total_ticks = ticks_reg;

    // datapath helpers
    always_comb
    begin
        cw         = rom_word(upc_reg);
        hit        = cvalid_reg && (chandle_reg == h_reg)
                     && (ccluster_reg == off_reg[CL+TAG_W-1:CL]);
        is_wr      = (cmd_reg == CMD_WRITE);
        direct     = !hit && (cnt_reg >= WORD_W'(CLUSTER_BYTES))
                     && (off_reg[CL-1:0] == '0);
        out_free   = !out_valid_reg || out_ready;
        room       = LW'(CLUSTER_BYTES) - LW'(off_reg[CL-1:0]);
        off_adv    = off_reg + WORD_W'(len_reg);
        recip_prod = MW'(prod_reg) * MW'(RECIP_1000);
        rem        = prod_reg - PW'(quo_reg * PW'(MEMCPY_DIV));
        if (fw_reg == FW_OLD)
        begin
            memcpy_cost = ADD_W'(len_reg) + ADD_W'(MEMCPY_OLD_BIAS);
        end
        else
        begin
            memcpy_cost = ADD_W'(quo_reg) + ADD_W'(MEMCPY_BIAS);
        end
    end

    // microcode operation decode
    always_comb
    begin
        cmd_next       = cmd_reg;
        h_next         = h_reg;
        off_next       = off_reg;
        cnt_next       = cnt_reg;
        fsize_next     = fsize_reg;
        len_next       = len_reg;
        prod_next      = prod_reg;
        quo_next       = quo_reg;
        cvalid_next    = cvalid_reg;
        chandle_next   = chandle_reg;
        ccluster_next  = ccluster_reg;
        cdirty_next    = cdirty_reg;
        sb_next        = sb_reg;
        ticks_next     = ticks_reg;
        out_valid_next = out_valid_reg && !out_ready;
        add_val        = '0;
        flush_req      = 1'b0;

        unique case (cw.op)
            OP_LATCH:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    h_next     = handle_mod(handle_index);
                    off_next   = current_offset;
                    cnt_next   = request_size;
                    fsize_next = file_length;
                end
            end
            OP_CLIP:
            begin
                if (cmd_reg == CMD_READ)
                begin
                    priority if (off_reg >= fsize_reg)
                        cnt_next = '0;
                    else if (cnt_reg > fsize_reg - off_reg)
                        cnt_next = fsize_reg - off_reg;
                    else
                        cnt_next = cnt_reg;
                end
            end
            OP_LEN:
            begin
                if (cnt_reg < WORD_W'(room))
                begin
                    len_next = cnt_reg[LW-1:0];
                end
                else
                begin
                    len_next = room;
                end
            end
            OP_FLUSH_MISS:
            begin
                flush_req = !hit;
            end
            OP_FILL:
            begin
                if (!hit)
                begin
                    if (off_reg < fsize_reg)
                    begin
                        add_val = cost_cluster_read(fw_reg);
                    end
                    cvalid_next   = 1'b1;
                    chandle_next  = h_reg;
                    ccluster_next = off_reg[CL+TAG_W-1:CL];
                end
            end
            OP_MUL:
            begin
                prod_next = PW'(len_reg) * PW'(MEMCPY_MUL);
            end
            OP_QUO:
            begin
                quo_next = recip_prod[MW-1:RECIP_SHIFT];
            end
            OP_FIX:
            begin
                if (rem >= PW'(MEMCPY_DIV))
                begin
                    quo_next = quo_reg + QW'(1);
                end
            end
            OP_COPY:
            begin
                add_val     = memcpy_cost + (is_wr ? ADD_W'(FREE_CHECK_TICKS) : '0);
                cdirty_next = is_wr;
            end
            OP_END_PIECE:
            begin
                off_next  = off_adv;
                cnt_next  = cnt_reg - WORD_W'(len_reg);
                flush_req = is_wr && (off_adv[CL-1:0] == '0);
            end
            OP_DIRECT:
            begin
                add_val  = is_wr ? cost_cluster_write(fw_reg) : cost_cluster_read(fw_reg);
                off_next = off_reg + WORD_W'(CLUSTER_BYTES);
                cnt_next = cnt_reg - WORD_W'(CLUSTER_BYTES);
                if (is_wr)
                begin
                    sb_next[h_reg] = 1'b1;
                end
            end
            OP_CLOSE_FLUSH:
            begin
                if (cvalid_reg && chandle_reg == h_reg)
                begin
                    flush_req   = 1'b1;
                    cvalid_next = 1'b0;
                end
            end
            OP_CLOSE_SB:
            begin
                if (sb_reg[h_reg])
                begin
                    add_val = cost_superblock(fw_reg);
                end
                sb_next[h_reg] = 1'b0;
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    ticks_next     = acc_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // write back a dirty cached cluster
        if (flush_req && cvalid_reg && cdirty_reg)
        begin
            cdirty_next          = 1'b0;
            sb_next[chandle_reg] = 1'b1;
            add_val              = cost_cluster_write(fw_reg);
        end

        // tick accumulator
        if (cw.op == OP_LATCH)
        begin
            acc_next = TICKS_W'(overhead_reg);
        end
        else
        begin
            acc_next = acc_reg + TICKS_W'(add_val);
        end
    end

    // step counter and conditional jumps
    always_comb
    begin
        unique case (cw.nxt)
            NX_SEQ:       upc_next = upc_reg + STEP_W'(1);
            NX_JUMP:      upc_next = cw.target;
            NX_WAIT_IN:   upc_next = in_valid ? upc_reg + STEP_W'(1) : upc_reg;
            NX_IF_CLOSE:  upc_next = (cmd_reg == CMD_CLOSE) ? cw.target
                                                            : upc_reg + STEP_W'(1);
            NX_IF_NOP:    upc_next = (cmd_reg != CMD_READ && cmd_reg != CMD_WRITE)
                                     ? cw.target : upc_reg + STEP_W'(1);
            NX_IF_DONE:   upc_next = (cnt_reg == '0) ? cw.target : upc_reg + STEP_W'(1);
            NX_IF_DIRECT: upc_next = direct ? cw.target : upc_reg + STEP_W'(1);
            NX_WAIT_OUT:  upc_next = out_free ? cw.target : upc_reg;
            default:      upc_next = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg       <= FW_OTHER;
            overhead_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_FIRMWARE_CLASS)
            begin
                fw_reg <= cfg_data[FW_W-1:0];
            end
            else if (cfg_index == CFG_OVERHEAD)
            begin
                overhead_reg <= cfg_data;
            end
        end
    end

    // control and cache state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= ST_IDLE;
            cvalid_reg    <= 1'b0;
            chandle_reg   <= '0;
            ccluster_reg  <= '0;
            cdirty_reg    <= 1'b0;
            sb_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            cvalid_reg    <= cvalid_next;
            chandle_reg   <= chandle_next;
            ccluster_reg  <= ccluster_next;
            cdirty_reg    <= cdirty_next;
            sb_reg        <= sb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        h_reg     <= h_next;
        off_reg   <= off_next;
        cnt_reg   <= cnt_next;
        fsize_reg <= fsize_next;
        acc_reg   <= acc_next;
        len_reg   <= len_next;
        prod_reg  <= prod_next;
        quo_reg   <= quo_next;
        ticks_reg <= ticks_next;
    end

endmodule

FILE: tb/sv/tb_cluster_cache_access_timing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cluster_cache_access_timing
// Self-checking bench for the cluster cache access timing block: a directed
// table of requests, then random file sessions and noise under several
// firmware classes and overheads. Every result is compared with a typed value
// or a tick estimate computed in the bench from its own copy of cache and flag state.
// ----------------------------------------------------------------------------
module tb_cluster_cache_access_timing;

    import cca_pkg::*;

    localparam int CLUSTER        = 16384;
    localparam int SLOTS          = 16;
    localparam int RESET_CYCLES   = 11;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 235;
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DIR_ROWS       = 28;

    // codes the package leaves unnamed
    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [FW_W-1:0]      FW_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 8'hFF;

    // tick costs
    localparam longint RD_OLD = 165000, RD_MID = 125000, RD_OTHER = 115000;
    localparam longint WR_OLD = 370000, WR_NEW = 300000;
    localparam longint SB_OLD = 4100000, SB_MID = 3350000, SB_OTHER = 3170000;
    localparam longint COPY_NUM = 636, COPY_DEN = 1000, COPY_BIAS = 150;
    localparam longint OLD_COPY_BIAS = 3, FREE_CHECK = 1000;

    typedef struct packed {
        logic                 reg_write;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [OVH_W-1:0]     reg_value;
        logic [CMD_W-1:0]     cmd;
        logic [HIDX_W-1:0]    handle;
        logic [WORD_W-1:0]    offset;
        logic [WORD_W-1:0]    size;
        logic [WORD_W-1:0]    fsize;
        logic                 known;
        logic [TICKS_W-1:0]   ticks;
    } vector_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [OVH_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [CMD_W-1:0]     command = '0;
    logic [HIDX_W-1:0]    handle_index = '0;
    logic [WORD_W-1:0]    current_offset = '0;
    logic [WORD_W-1:0]    request_size = '0;
    logic [WORD_W-1:0]    file_length = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [TICKS_W-1:0]   total_ticks;

    // bench copy of configuration and cache state
    logic [FW_W-1:0]      est_fw = FW_OTHER;
    logic [OVH_W-1:0]     est_overhead = '0;
    logic                 cached_ok = 1'b0;
    logic [HIDX_W-1:0]    cached_handle = '0;
    logic [15:0]          cached_cluster = '0;
    logic                 cached_dirty = 1'b0;
    logic [SLOTS-1:0]     sb_pending = '0;

    logic [TICKS_W-1:0]   ticks_due[$];
    logic [TICKS_W-1:0]   due_ticks;
    int                   fail_count = 0;
    int                   results_seen = 0;
    int                   requests_sent = 0;
    int                   cfg_writes = 0;
    int                   quiet_cycles = 0;
    bit                   send_calm = 1'b0;
    bit                   recv_calm = 1'b0;
    bit                   held_off = 1'b0;

    // directed table: typed results are only the ones obvious from the costs
    vector_t directed_rows [DIR_ROWS] = '{
        // zero-size read, read starting at end, unused command, idle close
        '{1'b0, 8'd0, 20'd0, CMD_READ,   4'd0,  32'd0,   32'd0,   32'd0,   1'b1, 48'd0},
        '{1'b0, 8'd0, 20'd0, CMD_READ,   4'd0,  32'd100, '1,      32'd100, 1'b1, 48'd0},
        '{1'b0, 8'd0, 20'd0, CMD_UNUSED, 4'd15, '1,      '1,      '1,      1'b1, 48'd0},
        '{1'b0, 8'd0, 20'd0, CMD_CLOSE,  4'd5,  32'd0,   32'd0,   32'd0,   1'b1, 48'd0},
        // direct cluster read and write, close with superblock
        '{1'b0, 8'd0, 20'd0, CMD_READ,   4'd1,  32'd0, 32'd16384, 32'd16384, 1'b1, 48'd115000},
        '{1'b0, 8'd0, 20'd0, CMD_WRITE,  4'd2,  32'd0, 32'd16384, 32'd0,     1'b1, 48'd300000},
        '{1'b0, 8'd0, 20'd0, CMD_CLOSE,  4'd2,  32'd0, 32'd0,     32'd0,     1'b1, 48'd3170000},
        // cached fill, cached write hit, close flushing a dirty cluster
        '{1'b0, 8'd0, 20'd0, CMD_READ,   4'd3,  32'd0,   32'd100, 32'd1000, 1'b1, 48'd115213},
        '{1'b0, 8'd0, 20'd0, CMD_WRITE,  4'd3,  32'd100, 32'd100, 32'd1000, 1'b1, 48'd1213},
        '{1'b0, 8'd0, 20'd0, CMD_CLOSE,  4'd3,  32'd0,   32'd0,   32'd0,    1'b1, 48'd3470000},
        // read clipped at end of file
        '{1'b0, 8'd0, 20'd0, CMD_READ,   4'd4,  32'd16000, '1,    32'd16384, 1'b1, 48'd115394},
        // write wrapping past 2^32, aliased cluster tag, close
        '{1'b0, 8'd0, 20'd0, CMD_WRITE,  4'd6,  32'hFFFF_FFF0, 32'd32, 32'd0, 1'b0, 48'd0},
        '{1'b0, 8'd0, 20'd0, CMD_READ,   4'd6,  32'h4000_0010, 32'd16, '1,    1'b0, 48'd0},
        '{1'b0, 8'd0, 20'd0, CMD_CLOSE,  4'd6,  32'd0,   32'd0,   32'd0,    1'b0, 48'd0},
        // unaligned multi-cluster write, eviction by another handle
        '{1'b0, 8'd0, 20'd0, CMD_WRITE,  4'd7,  32'd8000, 32'd49152, 32'd0,      1'b0, 48'd0},
        '{1'b0, 8'd0, 20'd0, CMD_READ,   4'd8,  32'd0,    32'd40000, 32'd100000, 1'b0, 48'd0},
        '{1'b0, 8'd0, 20'd0, CMD_WRITE,  4'd15, 32'd0,    32'd1,     32'd0,      1'b0, 48'd0},
        '{1'b0, 8'd0, 20'd0, CMD_CLOSE,  4'd7,  32'd0,    32'd0,     32'd0,      1'b0, 48'd0},
        // old firmware with full-scale overhead
        '{1'b1, CFG_FIRMWARE_CLASS, 20'(FW_OLD), CMD_READ, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0, 48'd0},
        '{1'b1, CFG_OVERHEAD, 20'hFFFFF, CMD_READ, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0, 48'd0},
        '{1'b0, 8'd0, 20'd0, CMD_UNUSED, 4'd0,  32'd0, 32'd0,     32'd0,     1'b1, 48'd1048575},
        '{1'b0, 8'd0, 20'd0, CMD_READ,   4'd9,  32'd0, 32'd16384, 32'd16384, 1'b1, 48'd1213575},
        '{1'b0, 8'd0, 20'd0, CMD_CLOSE,  4'd15, 32'd0, 32'd0,     32'd0,     1'b0, 48'd0},
        // spare register index ignored, unused firmware class code
        '{1'b1, CFG_SPARE, 20'hFFFFF, CMD_READ, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0, 48'd0},
        '{1'b1, CFG_FIRMWARE_CLASS, 20'hFFFFF, CMD_READ, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0, 48'd0},
        '{1'b0, 8'd0, 20'd0, CMD_READ,   4'd10, 32'd20, 32'd1000, 32'd5000, 1'b0, 48'd0},
        '{1'b0, 8'd0, 20'd0, CMD_WRITE,  4'd11, 32'h5555_5555, 32'd0, 32'hAAAA_AAAA,
          1'b0, 48'd0},
        '{1'b1, CFG_OVERHEAD, 20'd0, CMD_READ, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0, 48'd0}
    };

    cluster_cache_access_timing #(
        .HANDLE_SLOTS  (SLOTS),
        .CLUSTER_BYTES (CLUSTER)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .handle_index   (handle_index),
        .current_offset (current_offset),
        .request_size   (request_size),
        .file_length    (file_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .total_ticks    (total_ticks)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // tick estimate
    // ------------------------------------------------------------------
    function automatic longint rd_cost();
        case (est_fw)
            FW_OLD:  return RD_OLD;
            FW_MID:  return RD_MID;
            default: return RD_OTHER;
        endcase
    endfunction

    function automatic longint wr_cost();
        return (est_fw == FW_OLD) ? WR_OLD : WR_NEW;
    endfunction

    function automatic bit owns(input logic [HIDX_W-1:0] h, input logic [WORD_W-1:0] pos);
        return cached_ok && cached_handle == h && cached_cluster == 16'(pos / CLUSTER);
    endfunction

    // write back a dirty cluster and mark its handle for a superblock write
    function automatic longint spill();
        if (!cached_ok || !cached_dirty)
            return 0;
        cached_dirty = 1'b0;
        sb_pending[cached_handle] = 1'b1;
        return wr_cost();
    endfunction

    function automatic logic [TICKS_W-1:0] estimate_ticks(
        input logic [CMD_W-1:0]  cmd,
        input logic [HIDX_W-1:0] h,
        input logic [WORD_W-1:0] off,
        input logic [WORD_W-1:0] sz,
        input logic [WORD_W-1:0] fs
    );
        longint            t;
        logic              wr;
        logic [WORD_W-1:0] pos, left, len, nxt;
        t    = longint'(est_overhead);
        wr   = (cmd == CMD_WRITE);
        pos  = off;
        left = sz;
        if (cmd == CMD_READ || cmd == CMD_WRITE)
        begin
            // reads stop at end of file
            if (!wr)
            begin
                if (pos >= fs)
                    left = '0;
                else if (left > fs - pos)
                    left = fs - pos;
            end
            // one cluster piece per pass
            while (left != 0)
            begin
                if (!owns(h, pos) && left >= CLUSTER && (pos % CLUSTER) == 0)
                begin
                    t += wr ? wr_cost() : rd_cost();
                    len = CLUSTER;
                    if (wr)
                        sb_pending[h] = 1'b1;
                end
                else
                begin
                    if (!owns(h, pos))
                    begin
                        t += spill();
                        if (pos < fs)
                            t += rd_cost();
                        cached_ok      = 1'b1;
                        cached_handle  = h;
                        cached_cluster = 16'(pos / CLUSTER);
                    end
                    len = CLUSTER - (pos % CLUSTER);
                    if (len > left)
                        len = left;
                    if (est_fw == FW_OLD)
                        t += longint'(len) + OLD_COPY_BIAS;
                    else
                        t += (COPY_NUM * longint'(len)) / COPY_DEN + COPY_BIAS;
                    if (wr)
                        t += FREE_CHECK;
                    cached_dirty = wr;
                    nxt = pos + len;
                    if (wr && (nxt % CLUSTER) == 0)
                        t += spill();
                end
                pos  = pos + len;
                left = left - len;
            end
        end
        else if (cmd == CMD_CLOSE)
        begin
            if (cached_ok && cached_handle == h)
            begin
                t += spill();
                cached_ok = 1'b0;
            end
            if (sb_pending[h])
            begin
                case (est_fw)
                    FW_OLD:  t += SB_OLD;
                    FW_MID:  t += SB_MID;
                    default: t += SB_OTHER;
                endcase
            end
            sb_pending[h] = 1'b0;
        end
        return t[TICKS_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // request and register drivers
    // ------------------------------------------------------------------
    task automatic send_request(
        input logic [CMD_W-1:0]   cmd,
        input logic [HIDX_W-1:0]  h,
        input logic [WORD_W-1:0]  off,
        input logic [WORD_W-1:0]  sz,
        input logic [WORD_W-1:0]  fs,
        input logic               known,
        input logic [TICKS_W-1:0] known_ticks
    );
        int                 gap;
        logic [TICKS_W-1:0] guess;
        gap = send_calm ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        command        <= cmd;
        handle_index   <= h;
        current_offset <= off;
        request_size   <= sz;
        file_length    <= fs;
        do @(posedge clk); while (!in_ready);
        guess = estimate_ticks(cmd, h, off, sz, fs);
        ticks_due.push_back(known ? known_ticks : guess);
        if (cmd != CMD_UNUSED)
            requests_sent++;
    endtask

    // drop valid and wait until every item has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (ticks_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OVH_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_FIRMWARE_CLASS)
            est_fw = val[FW_W-1:0];
        else if (idx == CFG_OVERHEAD)
            est_overhead = val;
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int                p, k, n, scen, target;
        logic [CMD_W-1:0]  cmd;
        logic [FW_W-1:0]   fw_pick;
        logic [HIDX_W-1:0] h;
        logic [WORD_W-1:0] pos, sz, fs, val;
        logic [WORD_W:0]   stop;
        vector_t           row;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = directed_rows[r];
            if (row.reg_write)
            begin
                wait_idle();
                write_reg(row.reg_index, row.reg_value);
            end
            else
                send_request(row.cmd, row.handle, row.offset, row.size, row.fsize,
                             row.known, row.ticks);
        end

        // random phases, each under its own register setting
        for (p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p % 4)
                0:       fw_pick = FW_OLD;
                1:       fw_pick = FW_MID;
                2:       fw_pick = FW_OTHER;
                default: fw_pick = FW_UNUSED;
            endcase
            val = $urandom;
            val[FW_W-1:0] = fw_pick;
            write_reg(CFG_FIRMWARE_CLASS, val[OVH_W-1:0]);
            if (p == 0)
                write_reg(CFG_OVERHEAD, '0);
            else if (p == 1)
                write_reg(CFG_OVERHEAD, '1);
            else
                write_reg(CFG_OVERHEAD, OVH_W'($urandom));
            send_calm = (p % 3 == 1);
            recv_calm = (p % 4 == 2);
            target    = requests_sent + PHASE_ITEMS;

            while (requests_sent < target)
            begin
                scen = $urandom_range(0, 99);
                if (scen < 70)
                begin
                    // file session: a run of accesses on a handle, then mostly a close
                    h = HIDX_W'($urandom_range(0, SLOTS - 1));
                    if ($urandom_range(0, 5) == 0)
                    begin
                        fs  = '1;
                        pos = $urandom_range(32'hFFF0_0000, 32'hFFFF_FFFF);
                    end
                    else
                    begin
                        fs  = $urandom_range(0, 6 * CLUSTER);
                        pos = $urandom_range(0, 1) ? $urandom_range(0, 4) * CLUSTER
                                                   : $urandom_range(0, fs);
                    end
                    n = $urandom_range(2, 8);
                    for (k = 0; k < n; k++)
                    begin
                        cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
                        case ($urandom_range(0, 9))
                            0:          sz = '0;
                            1, 2, 3, 4: sz = $urandom_range(1, 4096);
                            5, 6:
                            begin
                                sz  = CLUSTER;
                                pos = pos - (pos % CLUSTER);
                            end
                            7, 8:       sz = $urandom_range(1, 3 * CLUSTER);
                            default:    sz = $urandom_range(3 * CLUSTER, 8 * CLUSTER);
                        endcase
                        send_request(cmd, h, pos, sz, fs, 1'b0, '0);
                        stop = {1'b0, pos} + sz;
                        if (cmd == CMD_WRITE)
                        begin
                            if (!stop[WORD_W] && stop[WORD_W-1:0] > fs)
                                fs = stop[WORD_W-1:0];
                            pos = stop[WORD_W-1:0];
                        end
                        else if (stop > {1'b0, fs})
                            pos = (pos > fs) ? pos : fs;
                        else
                            pos = stop[WORD_W-1:0];
                        if ($urandom_range(0, 9) == 0)
                            pos = $urandom_range(0, fs);
                        if ($urandom_range(0, 9) == 0)
                            h = HIDX_W'($urandom_range(0, SLOTS - 1));
                    end
                    if ($urandom_range(0, 4) != 0)
                        send_request(CMD_CLOSE, h, $urandom, $urandom, $urandom, 1'b0, '0);
                end
                else if (scen < 90)
                begin
                    // loose item with random fields, walk kept short
                    cmd = CMD_W'($urandom_range(0, 3));
                    h   = HIDX_W'($urandom);
                    pos = $urandom;
                    sz  = $urandom;
                    fs  = $urandom;
                    if (cmd == CMD_WRITE)
                    begin
                        sz = $urandom_range(0, 3 * CLUSTER);
                        if ($urandom_range(0, 3) == 0)
                            pos = 32'hFFFF_FFFF - $urandom_range(0, 2 * CLUSTER);
                    end
                    else if (cmd == CMD_READ && fs > pos && fs - pos > 8 * CLUSTER
                             && sz > 8 * CLUSTER)
                        fs = pos + $urandom_range(0, 3 * CLUSTER);
                    send_request(cmd, h, pos, sz, fs, 1'b0, '0);
                end
                else
                begin
                    // cluster tags that alias 2^30 bytes apart
                    h   = HIDX_W'($urandom_range(0, SLOTS - 1));
                    pos = $urandom_range(0, 4 * CLUSTER);
                    send_request(CMD_WRITE, h, pos, $urandom_range(1, 2 * CLUSTER),
                                 $urandom, 1'b0, '0);
                    pos = pos + (WORD_W'($urandom_range(1, 3)) << 30);
                    cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
                    send_request(cmd, h, pos, $urandom_range(1, 2 * CLUSTER), '1, 1'b0, '0);
                end
            end
        end

        // drain and report
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("checked %0d results from %0d requests and %0d register writes, %0d errors",
                 results_seen, requests_sent, cfg_writes, fail_count);
        $display("firmware class codes 0 to 3, overhead 0 to full scale, output hold-off %s",
                 held_off ? "exercised" : "not reached");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random stalls and one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held_off && results_seen >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = recv_calm ? 0 : $urandom_range(0, 9);
                if (stall != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // compare each result item with the oldest pending estimate
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (ticks_due.size() == 0)
            begin
                $error("result item with no request pending: total_ticks %0d", total_ticks);
                fail_count++;
            end
            else
            begin
                due_ticks = ticks_due.pop_front();
                if (total_ticks !== due_ticks)
                begin
                    $error("total_ticks mismatch: expected %0d, actual %0d",
                           due_ticks, total_ticks);
                    fail_count++;
                end
            end
            results_seen++;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $error("no handshake for %0d cycles, %0d results pending",
                   WATCHDOG_LIMIT, ticks_due.size());
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

FILE: files.f
rtl/cca_pkg.sv
rtl/cluster_cache_access_timing.sv
tb/sv/tb_cluster_cache_access_timing.sv
